>>> design/mipmap_box_downsample_core_assert.svh
// Assertion macros for the mipmap box downsample RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef MIPMAP_BOX_DOWNSAMPLE_CORE_ASSERT_SVH
`define MIPMAP_BOX_DOWNSAMPLE_CORE_ASSERT_SVH

// Clocked check, off while in reset.
`define MBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/mbd_pkg.sv
// Package for the mipmap box downsample core: constants, register map,
// pair-sum and rounding helpers. No dependencies.
`timescale 1ns / 1ps

package mbd_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned SUM_W      = 9;
  localparam int unsigned PAIR_W     = 4 * SUM_W;
  localparam int unsigned CFG_W_W    = 11;
  localparam int unsigned CFG_H_W    = 14;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 8192;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = CFG_W_W'(256);
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(256);

  typedef enum logic {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // Per-channel 9-bit sums of two pixels, B in the low field.
  function automatic pair_t pair_sum(input pixel_t x, input pixel_t y);
    pair_t res;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      res[ch*SUM_W +: SUM_W] = {1'b0, x[ch*CH_W +: CH_W]} + {1'b0, y[ch*CH_W +: CH_W]};
    end
    return res;
  endfunction

  // (upper + lower + 2) >> 2 per channel.
  function automatic pixel_t finish_average(input pair_t upper, input pair_t lower);
    pixel_t     res;
    logic [9:0] s;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      s = {1'b0, upper[ch*SUM_W +: SUM_W]} + {1'b0, lower[ch*SUM_W +: SUM_W]} + 10'd2;
      res[ch*CH_W +: CH_W] = s[9:2];
    end
    return res;
  endfunction

endpackage

>>> design/mipmap_box_downsample_core.sv
// Top level of the 2x2 box-filter mip level generator with APB registers.
// Depends on mbd_pkg, mbd_line_buf and mipmap_box_downsample_core_assert.svh.
// Accepts one ARGB8888 source texel per clock unless stalled, in raster order,
// and emits one averaged texel per 2x2 block, (A+B+C+D+2)>>2 per channel, on odd
// rows at odd columns; tlast marks the last texel of the level. Each texel makes
// at most one access to a single-port line buffer of MaxWidth/2 x 36 bits, so
// the block sustains one transfer per clock while the output is not stalled; a
// result is held in stage 1 and moves to the output register when the output is
// free. A trailing odd column or row is consumed without output. The line buffer
// needs no clearing after reset. Width and height writes take effect at the next
// transfer; grow the width between frames only.
`timescale 1ns / 1ps

`include "mipmap_box_downsample_core_assert.svh"

module mipmap_box_downsample_core
  import mbd_pkg::*;
#(
  parameter int unsigned MaxWidth = MAX_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // source texels
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // [31:0] in_pixel
  // mip texels
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,   // [31:0] out_pixel
  output logic              m_axis_tlast
);

  localparam int unsigned Depth = MaxWidth / 2;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ColW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CntW  = ColW + 1;

  // registers
  logic [CFG_W_W-1:0] width_q;
  logic [CFG_H_W-1:0] height_q;
  logic               cfg_we;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SRC_WIDTH:  width_q  <= pwdata[CFG_W_W-1:0];
        REG_SRC_HEIGHT: height_q <= pwdata[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SRC_WIDTH:  prdata = {{(APB_DW-CFG_W_W){1'b0}}, width_q};
      REG_SRC_HEIGHT: prdata = {{(APB_DW-CFG_H_W){1'b0}}, height_q};
      default:        prdata = '0;
    endcase
  end

  // effective dimensions
  logic [31:0]        w_ext;
  logic [31:0]        h_ext;
  logic [CntW-1:0]    eff_w;
  logic [CFG_H_W-1:0] eff_h;
  logic [CntW-1:0]    used_w;
  logic [CFG_H_W-1:0] used_h;

  always_comb begin
    w_ext = {{(32-CFG_W_W){1'b0}}, width_q};
    h_ext = {{(32-CFG_H_W){1'b0}}, height_q};
    if (w_ext < 32'd2) begin
      w_ext = 32'd2;
    end else if (w_ext > MaxWidth) begin
      w_ext = MaxWidth;
    end
    if (h_ext < 32'd2) begin
      h_ext = 32'd2;
    end else if (h_ext > MAX_HEIGHT) begin
      h_ext = MAX_HEIGHT;
    end
    eff_w  = w_ext[CntW-1:0];
    eff_h  = h_ext[CFG_H_W-1:0];
    used_w = {eff_w[CntW-1:1], 1'b0};
    used_h = {eff_h[CFG_H_W-1:1], 1'b0};
  end

  // position counters
  logic [ColW-1:0]  col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  pixel_t           left_q;
  logic [CntW-1:0]  col_ext, col_inc;
  logic [CFG_H_W-1:0] row_ext, row_inc;
  logic             in_xfer;
  logic             active;
  logic             odd_col;
  logic             odd_row;
  logic             mem_we;
  logic             mem_re;
  logic             last_pos;
  pair_t            ps;
  pair_t            rd_data;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign col_ext  = {1'b0, col_q};
  assign row_ext  = {1'b0, row_q};
  assign col_inc  = col_ext + CntW'(1);
  assign row_inc  = row_ext + CFG_H_W'(1);
  assign active   = (col_ext < used_w) && (row_ext < used_h);
  assign odd_col  = col_q[0];
  assign odd_row  = row_q[0];
  assign mem_we   = in_xfer && active && odd_col && !odd_row;
  assign mem_re   = in_xfer && active && odd_col && odd_row;
  assign ps       = pair_sum(left_q, s_axis_tdata);
  assign last_pos = (col_ext == used_w - CntW'(1)) && (row_ext == used_h - CFG_H_W'(1));

  always_comb begin
    if (col_inc >= eff_w) begin
      col_d = '0;
      row_d = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
      row_d = (row_ext >= eff_h) ? '0 : row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
      if (active && !odd_col) begin
        left_q <= s_axis_tdata;
      end
    end
  end

  mbd_line_buf #(
    .Depth(Depth)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (AddrW'(col_q >> 1)),
    .wdata_i(ps),
    .rdata_o(rd_data)
  );

  // stage 1: lower pair sum waits for the line buffer read
  logic   s1_valid_q;
  logic   s1_last_q;
  pair_t  s1_ps_q;
  logic   out_free;
  logic   s1_adv;
  logic   out_valid_q;
  logic   out_last_q;
  pixel_t out_pix_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= mem_re;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_ps_q   <= ps;
      s1_last_q <= last_pos;
    end
    if (s1_adv) begin
      out_pix_q  <= finish_average(rd_data, s1_ps_q);
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  `MBD_ASSERT_ALWAYS(a_no_rw_collision, !(mem_we && mem_re), "line buffer read and write collide")
  `MBD_ASSERT(a_read_fills_s1, mem_re |=> s1_valid_q, "line buffer read lost its stage")
  `MBD_ASSERT(a_s1_hold, (s1_valid_q && !s1_adv) |=> ($stable(rd_data) && s1_valid_q), "stalled read data changed")
  `MBD_ASSERT(a_odd_only, mem_re |-> (odd_col && odd_row), "read outside an odd row and column")

endmodule

>>> design/mbd_line_buf.sv
// Line buffer of horizontal pair sums: one synchronous port, read data registered.
// Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_line_buf
  import mbd_pkg::*;
#(
  parameter int unsigned Depth = MAX_WIDTH / 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  pair_t            wdata_i,
  output pair_t            rdata_o
);

  pair_t mem_q [Depth];
  pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
